@@ rtl/core/brle_pkg.sv @@
// ----------------------------------------------------------------------------
// brle_pkg
// Shared types and constants of the byte run-length encoder.
// ----------------------------------------------------------------------------
package brle_pkg;

  localparam int CNT_W      = 7;    // packet byte count
  localparam int WORD_W     = 64;   // result word
  localparam int WCNT_W     = 4;    // bytes in a result word
  localparam int LEN_W      = 8;    // packet length including header

  localparam logic [7:0]       LIT_FLAG = 8'h80;
  localparam logic [CNT_W-1:0] RUN_MIN  = 7'd3;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // packet queued for output
  typedef struct packed {
    logic             run;
    logic [7:0]       hdr;
    logic [7:0]       run_byte;
    logic [LEN_W-1:0] len;
  } emit_t;

endpackage

@@ rtl/core/brle_ifs.sv @@
// ----------------------------------------------------------------------------
// brle_ifs
// Valid/ready channels of the byte run-length encoder.
// ----------------------------------------------------------------------------
interface brle_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] in_byte;

  modport source (output valid, action, in_byte, input ready);
  modport sink   (input valid, action, in_byte, output ready);
endinterface

interface brle_out_if;
  logic                            valid;
  logic                            ready;
  logic [brle_pkg::WORD_W-1:0]     out_word;
  logic [brle_pkg::WCNT_W-1:0]     out_count;
  logic                            packet_end;

  modport source (output valid, out_word, out_count, packet_end, input ready);
  modport sink   (input valid, out_word, out_count, packet_end, output ready);
endinterface

@@ rtl/core/byte_run_length_encoder_unit.sv @@
// An item that closes no packet leaves the unit idle; in_ch.ready stays high.
// An item that emits a packet drops in_ch.ready while it goes out: a literal of n bytes as
// ceil((n+1)/BYTES_PER_WORD) words, a run as one, one result word per cycle while out_ch.ready is high.
// Literal bytes come from a row memory of BYTES_PER_WORD bytes, one row read per word.
// Reset (rst, synchronous) empties the open packet; the byte memory is not cleared,
// and a row can be read before all of its bytes have been written.
// ----------------------------------------------------------------------------
// byte_run_length_encoder_unit
// Packs a byte stream into literal and run packets and sends each packet
// as a series of words.
// ----------------------------------------------------------------------------
module byte_run_length_encoder_unit #(
  parameter int MAX_PACKET_COUNT = 127,
  parameter int BYTES_PER_WORD   = 8
) (
  input  logic              clk,
  input  logic              rst,
  brle_in_if.sink           in_ch,
  brle_out_if.source        out_ch
);

  localparam int ROWS   = MAX_PACKET_COUNT / BYTES_PER_WORD + 1;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LANE_W = (BYTES_PER_WORD > 1) ? $clog2(BYTES_PER_WORD) : 1;
  localparam int CW     = brle_pkg::CNT_W;
  localparam int LW     = brle_pkg::LEN_W;

  // state
  brle_pkg::state_t  state, state_next;
  logic              run_mode;
  logic [CW-1:0]     packet_count;
  logic [7:0]        first_byte;   // entry 0, the run byte in run mode
  logic [7:0]        last1, last2; // last two literal bytes
  logic [ROW_W-1:0]  pos_row;
  logic [LANE_W-1:0] pos_lane;

  // byte memory, one row per output word
  logic [BYTES_PER_WORD-1:0][7:0] mem [ROWS];
  logic [BYTES_PER_WORD-1:0][7:0] rd_q;

  // step results
  logic              in_acc, out_acc;
  logic              step_emit;
  brle_pkg::emit_t   step_pkt;
  logic              step_run;
  logic [CW-1:0]     step_cnt;
  logic [7:0]        step_first, step_last1, step_last2;
  logic              step_wr;
  logic [ROW_W-1:0]  step_row;
  logic [LANE_W-1:0] step_lane;
  logic              lane_wrap;
  logic [ROW_W-1:0]  row_inc;
  logic [LANE_W-1:0] lane_inc;

  // emission
  brle_pkg::emit_t   pkt;
  logic [LW-1:0]     rem;
  logic              first_word;
  logic [ROW_W-1:0]  rd_row;
  logic [7:0]        carry;
  logic              word_last;
  logic [brle_pkg::WCNT_W-1:0] word_cnt;
  logic [BYTES_PER_WORD-1:0][7:0] src;
  logic [brle_pkg::WORD_W-1:0]    word;

  // write held back while a packet drains
  logic              dw_en;
  logic [ROW_W-1:0]  dw_row;
  logic [LANE_W-1:0] dw_lane;
  logic [7:0]        dw_data;

  // memory ports
  logic              mem_we;
  logic [ROW_W-1:0]  mem_wrow;
  logic [LANE_W-1:0] mem_wlane;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [ROW_W-1:0]  mem_rrow;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      brle_pkg::ST_IDLE: begin
        if (in_acc && step_emit) state_next = brle_pkg::ST_EMIT;
      end
      brle_pkg::ST_EMIT: begin
        if (out_acc && word_last) state_next = brle_pkg::ST_IDLE;
      end
      default: state_next = brle_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    case (state)
      brle_pkg::ST_IDLE: in_ch.ready  = 1'b1;
      brle_pkg::ST_EMIT: out_ch.valid = 1'b1;
      default: begin
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;
      end
    endcase
  end

  // encoding step for one item
  always_comb begin
    logic [CW-1:0] c;
    logic          r;
    logic          b_eq_first;
    logic          triple3;
    logic [7:0]    b;

    b          = in_ch.in_byte;
    c          = packet_count;
    r          = run_mode;
    b_eq_first = (b == first_byte);
    triple3    = (first_byte == last2) && (last2 == last1);

    step_emit         = 1'b0;
    step_pkt.run      = run_mode;
    step_pkt.hdr      = run_mode ? {1'b0, packet_count} : (brle_pkg::LIT_FLAG | {1'b0, packet_count});
    step_pkt.run_byte = first_byte;
    step_pkt.len      = run_mode ? LW'(2) : ({1'b0, packet_count} + LW'(1));
    step_run          = run_mode;
    step_cnt          = packet_count;
    step_first        = first_byte;
    step_last1        = last1;
    step_last2        = last2;
    step_wr           = 1'b0;
    step_row          = pos_row;
    step_lane         = pos_lane;

    if (in_ch.action) begin
      step_emit = 1'b1;
      step_run  = 1'b0;
      step_cnt  = '0;
    end else begin
      // full packet goes out first, then an empty literal
      if (packet_count >= CW'(MAX_PACKET_COUNT)) begin
        step_emit = 1'b1;
        c         = '0;
        r         = 1'b0;
        step_run  = 1'b0;
        step_row  = '0;
        step_lane = '0;
      end

      if ((c < brle_pkg::RUN_MIN) ||
          ((c == brle_pkg::RUN_MIN) && !r && !triple3)) begin
        step_wr    = 1'b1;
        step_cnt   = c + CW'(1);
        step_last1 = b;
        step_last2 = last1;
        if (c == '0) step_first = b;
      end else if (r || (c == brle_pkg::RUN_MIN)) begin
        if (!b_eq_first) begin
          // run broken: send it, open a literal with this byte
          step_emit         = 1'b1;
          step_pkt.run      = 1'b1;
          step_pkt.hdr      = {1'b0, c};
          step_pkt.run_byte = first_byte;
          step_pkt.len      = LW'(2);
          step_run          = 1'b0;
          step_cnt          = CW'(1);
          step_first        = b;
          step_last1        = b;
          step_wr           = 1'b1;
          step_row          = '0;
          step_lane         = '0;
        end else begin
          step_run = 1'b1;
          step_cnt = c + CW'(1);
        end
      end else begin
        step_wr    = 1'b1;
        step_cnt   = c + CW'(1);
        step_last1 = b;
        step_last2 = last1;
        if ((b == last1) && (last1 == last2)) begin
          // three equal bytes at the tail: send the rest, start a run
          step_emit         = 1'b1;
          step_pkt.run      = 1'b0;
          step_pkt.hdr      = brle_pkg::LIT_FLAG | {1'b0, c - CW'(2)};
          step_pkt.len      = {1'b0, c} - LW'(1);
          step_run          = 1'b1;
          step_first        = b;
          step_cnt          = brle_pkg::RUN_MIN;
        end
      end
    end
  end

  // next append position
  assign lane_wrap = (step_lane == LANE_W'(BYTES_PER_WORD - 1));
  assign row_inc   = lane_wrap ? step_row + ROW_W'(1) : step_row;
  assign lane_inc  = lane_wrap ? '0 : step_lane + LANE_W'(1);

  // output word
  always_comb begin
    for (int k = 0; k < BYTES_PER_WORD; k++) begin
      src[k] = pkt.run ? pkt.run_byte : rd_q[k];
    end
  end

  assign word_last = (rem <= LW'(BYTES_PER_WORD));
  assign word_cnt  = word_last ? rem[brle_pkg::WCNT_W-1:0] : brle_pkg::WCNT_W'(BYTES_PER_WORD);

  for (genvar k = 0; k < 8; k++) begin : g_byte
    if (k == 0) begin : g_head
      assign word[7:0] = first_word ? pkt.hdr : carry;
    end else if (k < BYTES_PER_WORD) begin : g_data
      assign word[8*k +: 8] = (brle_pkg::WCNT_W'(k) < word_cnt) ? src[k-1] : 8'h00;
    end else begin : g_zero
      assign word[8*k +: 8] = 8'h00;
    end
  end

  assign out_ch.out_word   = word;
  assign out_ch.out_count  = word_cnt;
  assign out_ch.packet_end = word_last;

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_wrow  = step_row;
    mem_wlane = step_lane;
    mem_wdata = in_ch.in_byte;
    mem_re    = 1'b0;
    mem_rrow  = '0;
    if (state == brle_pkg::ST_IDLE) begin
      mem_we = in_acc && step_wr && !step_emit;
      mem_re = in_acc && step_emit;
    end else begin
      mem_wrow  = dw_row;
      mem_wlane = dw_lane;
      mem_wdata = dw_data;
      mem_we    = out_acc && word_last && dw_en;
      mem_re    = out_acc && !word_last;
      mem_rrow  = rd_row + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wrow][mem_wlane] <= mem_wdata;
    if (mem_re) rd_q <= mem[mem_rrow];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= brle_pkg::ST_IDLE;
      run_mode     <= 1'b0;
      packet_count <= '0;
      pos_row      <= '0;
      pos_lane     <= '0;
      dw_en        <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        run_mode     <= step_run;
        packet_count <= step_cnt;
        if (step_wr) begin
          pos_row  <= row_inc;
          pos_lane <= lane_inc;
        end else if (in_ch.action) begin
          pos_row  <= '0;
          pos_lane <= '0;
        end
        dw_en <= step_wr && step_emit;
      end else if (mem_we && (state == brle_pkg::ST_EMIT)) begin
        dw_en <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      first_byte <= step_first;
      last1      <= step_last1;
      last2      <= step_last2;
      dw_row     <= step_row;
      dw_lane    <= step_lane;
      dw_data    <= in_ch.in_byte;
      if (step_emit) begin
        pkt        <= step_pkt;
        rem        <= step_pkt.len;
        first_word <= 1'b1;
        rd_row     <= '0;
      end
    end else if (out_acc && !word_last) begin
      rem        <= rem - LW'(BYTES_PER_WORD);
      first_word <= 1'b0;
      carry      <= src[BYTES_PER_WORD-1];
      rd_row     <= rd_row + ROW_W'(1);
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    packet_count <= CW'(MAX_PACKET_COUNT))
    else $error("packet count above limit");

  a_run_min: assert property (@(posedge clk) disable iff (rst)
    run_mode |-> (packet_count >= brle_pkg::RUN_MIN))
    else $error("run shorter than three bytes");

  a_word_count: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.out_count != '0) &&
                     (out_ch.out_count <= brle_pkg::WCNT_W'(BYTES_PER_WORD)))
    else $error("word byte count out of range");

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_acc && out_ch.packet_end) |=> in_ch.ready && !out_ch.valid)
    else $error("encoder not idle after packet end");

endmodule

@@ tb/byte_run_length_encoder_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_run_length_encoder_unit_tb
// Streams data bytes and finish items into the encoder and checks every packet
// word against an in-bench model of the literal/run packing rules.
// ----------------------------------------------------------------------------
module byte_run_length_encoder_unit_tb;

  localparam int MAX_PKT     = 127;
  localparam int WORD_BYTES  = 8;
  localparam int IDLE_LIMIT  = 20000;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 40;
  localparam int ITEM_TARGET = 460;

  localparam logic ACT_DATA   = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  typedef struct {
    logic       action;
    logic [7:0] data;
    bit         drain;  // wait until all packet words are out before offering
  } byte_item_t;

  typedef struct {
    logic [brle_pkg::WORD_W-1:0] word;
    logic [brle_pkg::WCNT_W-1:0] count;
    logic                        last;
  } pkt_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  brle_in_if  in_ch ();
  brle_out_if out_ch ();

  byte_run_length_encoder_unit #(
    .MAX_PACKET_COUNT (MAX_PKT),
    .BYTES_PER_WORD   (WORD_BYTES)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  byte_item_t byte_items[$];
  pkt_word_t  expected_words[$];

  int total_items;
  int items_in;
  int finishes_in;
  int words_out;
  int packets_out;
  int full_flushes;
  int errors;
  int idle_cycles;

  // encoder model state
  logic       in_run;
  int         open_cnt;
  logic [7:0] held_bytes [0:127];
  logic [7:0] pkt_buf [0:128];

  // ---------------------------------------------------------------- model

  task automatic queue_packet(input int len);
    int pos;
    int c;
    int i;
    pkt_word_t w;
    pos = 0;
    while (pos < len) begin
      c = (len - pos > WORD_BYTES) ? WORD_BYTES : len - pos;
      w.word = '0;
      for (i = 0; i < c; i++) begin
        w.word[8*i +: 8] = pkt_buf[pos + i];
      end
      w.count = brle_pkg::WCNT_W'(c);
      w.last  = (pos + c >= len);
      expected_words.push_back(w);
      pos += c;
    end
  endtask

  task automatic queue_literal(input int n);
    int i;
    pkt_buf[0] = brle_pkg::LIT_FLAG | 8'(n & 8'h7f);
    for (i = 0; i < n; i++) begin
      pkt_buf[i + 1] = held_bytes[i];
    end
    queue_packet(n + 1);
  endtask

  task automatic queue_run(input int n);
    pkt_buf[0] = 8'(n & 8'h7f);
    pkt_buf[1] = held_bytes[0];
    queue_packet(2);
  endtask

  task automatic queue_open_packet();
    if (in_run) begin
      queue_run(open_cnt);
    end else begin
      queue_literal(open_cnt);
    end
  endtask

  task automatic encode_item(input logic act, input logic [7:0] b);
    int n;
    if (act == ACT_FINISH) begin
      queue_open_packet();
      in_run   = 1'b0;
      open_cnt = 0;
    end else begin
      if (open_cnt >= MAX_PKT) begin
        queue_open_packet();
        full_flushes++;
        in_run   = 1'b0;
        open_cnt = 0;
      end
      n = open_cnt;
      if (n < int'(brle_pkg::RUN_MIN)) begin
        held_bytes[n] = b;
        open_cnt = n + 1;
      end else if (n == int'(brle_pkg::RUN_MIN) && !in_run &&
                   !(held_bytes[0] == held_bytes[1] && held_bytes[1] == held_bytes[2])) begin
        // three mixed bytes: append without looking for a run
        held_bytes[n] = b;
        open_cnt = n + 1;
      end else if (n == int'(brle_pkg::RUN_MIN) || in_run) begin
        in_run = 1'b1;
        if (b != held_bytes[0]) begin
          queue_run(n);
          in_run        = 1'b0;
          held_bytes[0] = b;
          open_cnt      = 1;
        end else begin
          open_cnt = n + 1;
        end
      end else begin
        held_bytes[n] = b;
        n++;
        open_cnt = n;
        // literal ending in three equal bytes splits into literal plus run
        if (held_bytes[n-1] == held_bytes[n-2] && held_bytes[n-2] == held_bytes[n-3]) begin
          queue_literal(n - int'(brle_pkg::RUN_MIN));
          in_run        = 1'b1;
          held_bytes[0] = b;
          open_cnt      = int'(brle_pkg::RUN_MIN);
        end
      end
    end
  endtask

  // ------------------------------------------------------------- stimulus

  task automatic add_item(input logic act, input logic [7:0] b, input bit drain);
    byte_item_t it;
    it.action = act;
    it.data   = b;
    it.drain  = drain;
    byte_items.push_back(it);
  endtask

  task automatic add_bytes(input logic [7:0] b, input int len);
    int i;
    for (i = 0; i < len; i++) begin
      add_item(ACT_DATA, b, 1'b0);
    end
  endtask

  task automatic add_directed();
    add_item(ACT_FINISH, 8'hff, 1'b0);   // finish on empty, byte ignored
    add_item(ACT_DATA, 8'h00, 1'b0);
    add_item(ACT_DATA, 8'hff, 1'b0);
    add_item(ACT_DATA, 8'h55, 1'b0);
    add_item(ACT_FINISH, 8'h00, 1'b0);
    add_bytes(8'haa, 4);                 // literal of three turns into a run
    add_item(ACT_DATA, 8'h01, 1'b0);     // run broken
    add_item(ACT_FINISH, 8'h00, 1'b0);
    add_item(ACT_DATA, 8'h01, 1'b0);     // mixed three, then tail triple
    add_bytes(8'h02, 4);
    add_item(ACT_DATA, 8'h03, 1'b0);
    add_item(ACT_FINISH, 8'h00, 1'b0);
  endtask

  task automatic add_long_literal();
    int i;
    int len;
    logic [7:0] b;
    logic [7:0] prev;
    len  = $urandom_range(128, 136);
    prev = 8'($urandom);
    for (i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (b == prev) b = b ^ 8'h01;
      add_item(ACT_DATA, b, 1'b0);
      prev = b;
    end
  endtask

  task automatic add_segment();
    int kind;
    int len;
    int i;
    logic [7:0] base;
    kind = $urandom_range(0, 9);
    base = 8'($urandom);
    case (kind)
      0, 1, 2, 3: begin
        // narrow alphabet gives many short runs and literal splits
        len = $urandom_range(1, 24);
        for (i = 0; i < len; i++) begin
          add_item(ACT_DATA, base + 8'($urandom_range(0, 2)), 1'b0);
        end
      end
      4, 5: add_bytes(base, $urandom_range(1, 12));
      6: begin
        len = $urandom_range(1, 16);
        for (i = 0; i < len; i++) begin
          add_item(ACT_DATA, 8'($urandom), 1'b0);
        end
      end
      7: add_item(ACT_FINISH, base, 1'b0);
      8: begin
        add_item(ACT_FINISH, base, 1'b0);
        add_item(ACT_FINISH, ~base, 1'b0);
      end
      default: add_item(ACT_DATA ^ 1'($urandom), base, 1'b0);
    endcase
  endtask

  task automatic add_random();
    bit long_lit_done;
    bit long_run_done;
    long_lit_done = 1'b0;
    long_run_done = 1'b0;
    add_item(ACT_DATA, 8'($urandom), 1'b1);
    while (byte_items.size() < ITEM_TARGET) begin
      if (!long_lit_done && byte_items.size() > 80) begin
        add_long_literal();
        long_lit_done = 1'b1;
      end else if (!long_run_done && byte_items.size() > 260) begin
        add_item(ACT_DATA, 8'h3c, 1'b1);
        add_bytes(8'h3c, $urandom_range(127, 135));
        long_run_done = 1'b1;
      end else begin
        add_segment();
      end
    end
    add_item(ACT_FINISH, 8'($urandom), 1'b0);
  endtask

  // ---------------------------------------------------------------- driver

  int         burst_left;
  int         gap_left;
  bit         offer;
  byte_item_t cur_item;

  always @(posedge clk) begin
    if (!rst) begin
      if (!(in_ch.valid && !in_ch.ready)) begin
        offer = 1'b0;
        if (burst_left == 0) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        // a drain item waits for a quiet input and an empty expectation list
        if (burst_left > 0 && byte_items.size() != 0 &&
            !(byte_items[0].drain && (in_ch.valid || expected_words.size() != 0))) begin
          cur_item = byte_items.pop_front();
          offer    = 1'b1;
          burst_left--;
        end
        in_ch.valid <= offer;
        if (offer) begin
          in_ch.action  <= cur_item.action;
          in_ch.in_byte <= cur_item.data;
        end
      end
    end
  end

  // -------------------------------------------------------- receiver ready

  int       seg_left;
  int       seg_mode;
  int       hold_left;
  bit       hold_done;
  bit [7:0] stall_mask;
  bit [2:0] stall_phase;
  bit       next_ready;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (!hold_done && items_in >= 120) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (seg_left == 0) begin
        seg_mode   = $urandom_range(0, 3);
        seg_left   = $urandom_range(10, 150);
        stall_mask = 8'($urandom) | 8'h01;
      end else begin
        seg_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        case (seg_mode)
          0:       next_ready = 1'b1;
          1:       next_ready = ($urandom_range(0, 3) != 0);
          2:       next_ready = stall_mask[stall_phase];
          default: next_ready = 1'($urandom);
        endcase
      end
      stall_phase++;
      out_ch.ready <= next_ready;
    end
  end

  // --------------------------------------------------------------- monitor

  pkt_word_t exp_word;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        encode_item(in_ch.action, in_ch.in_byte);
        items_in++;
        if (in_ch.action == ACT_FINISH) finishes_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        words_out++;
        if (out_ch.packet_end) packets_out++;
        if (expected_words.size() == 0) begin
          $error("unexpected packet word %h count %0d", out_ch.out_word, out_ch.out_count);
          errors++;
        end else begin
          exp_word = expected_words.pop_front();
          if (out_ch.out_word !== exp_word.word) begin
            $error("out_word: expected %h, actual %h", exp_word.word, out_ch.out_word);
            errors++;
          end
          if (out_ch.out_count !== exp_word.count) begin
            $error("out_count: expected %0d, actual %0d", exp_word.count, out_ch.out_count);
            errors++;
          end
          if (out_ch.packet_end !== exp_word.last) begin
            $error("packet_end: expected %0d, actual %0d", exp_word.last, out_ch.packet_end);
            errors++;
          end
        end
      end
    end
  end

  // -------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ------------------------------------------------------------------ main

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_DATA;
    in_ch.in_byte = 8'h00;
    out_ch.ready  = 1'b0;
    in_run        = 1'b0;
    open_cnt      = 0;
    add_directed();
    add_random();
    total_items = byte_items.size();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (items_in < total_items || expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d items (%0d finish) giving %0d words in %0d packets",
             items_in, finishes_in, words_out, packets_out);
    $display("full-size flushes %0d, receiver hold of %0d cycles, drain pauses taken",
             full_flushes, LONG_HOLD);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/brle_pkg.sv
rtl/core/brle_ifs.sv
rtl/core/byte_run_length_encoder_unit.sv
tb/byte_run_length_encoder_unit_tb.sv
